// File: rtl/line_segment_window_clip_core_defines.svh
// Assertion macros used by the checker file.
`ifndef LINE_SEGMENT_WINDOW_CLIP_CORE_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIP_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define LSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsclip check failed");

// Check cons in the cycle after ante.
`define LSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsclip check failed");

`endif

// File: rtl/lsclip_pkg.sv
`default_nettype none
package lsclip_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV,
        DV_SAT
    } t_div_state;

    typedef logic [3:0] t_outcode;

    localparam t_outcode OC_ROW_LO = 4'h1;
    localparam t_outcode OC_ROW_HI = 4'h2;
    localparam t_outcode OC_COL_HI = 4'h4;
    localparam t_outcode OC_COL_LO = 4'h8;

    localparam logic [2:0] MAX_PASSES = 3'd4;

    localparam logic [1:0] REG_ROW_MIN = 2'd0;
    localparam logic [1:0] REG_ROW_MAX = 2'd1;
    localparam logic [1:0] REG_COL_MIN = 2'd2;
    localparam logic [1:0] REG_COL_MAX = 2'd3;

endpackage
`default_nettype wire

// File: rtl/lsclip_interp.sv
`default_nettype none
module lsclip_interp import lsclip_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire logic signed [COORD_BITS-1:0] i_a1,
    input  wire logic signed [COORD_BITS-1:0] i_a2,
    input  wire logic signed [COORD_BITS-1:0] i_b1,
    input  wire logic signed [COORD_BITS-1:0] i_b2,
    input  wire logic signed [COORD_BITS-1:0] i_edge,
    output logic                          o_done,
    output logic signed [COORD_BITS-1:0]  o_result
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * C + 1;
    localparam int SW = C + 3;
    localparam int CW = $clog2(PW + 1);

    t_div_state r_state, n_state;

    logic [DW-1:0]           r_ud, n_ud, r_ue, n_ue, r_uk, n_uk, r_rem, n_rem;
    logic [PW-1:0]           r_prod, n_prod;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_neg, n_neg, r_done, n_done;
    logic signed [C-1:0]     r_a1, n_a1, r_result, n_result;

    logic signed [DW-1:0]    w_d, w_e, w_k;
    logic [2*DW-1:0]         w_mul;
    logic [DW:0]             w_rem_sh, w_trial;
    logic                    w_ge;
    logic                    w_over;
    logic [C+1:0]            w_qlim;
    logic signed [SW-1:0]    w_a1x, w_qx, w_sum;
    logic signed [C-1:0]     w_sat;

    assign w_d = {i_a2[C-1], i_a2} - {i_a1[C-1], i_a1};
    assign w_e = {i_edge[C-1], i_edge} - {i_b1[C-1], i_b1};
    assign w_k = {i_b2[C-1], i_b2} - {i_b1[C-1], i_b1};

    assign w_mul    = r_ud * r_ue;
    assign w_rem_sh = {r_rem, r_prod[PW-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_uk};
    assign w_ge     = !w_trial[DW];

    assign w_over = |r_prod[PW-1:C+1];
    assign w_qlim = w_over ? {1'b1, {(C+1){1'b0}}} : {1'b0, r_prod[C:0]};
    assign w_a1x  = {{3{r_a1[C-1]}}, r_a1};
    assign w_qx   = {1'b0, w_qlim};
    assign w_sum  = r_neg ? (w_a1x - w_qx) : (w_a1x + w_qx);

    always_comb begin
        if ((&w_sum[SW-1:C-1]) || !(|w_sum[SW-1:C-1])) begin
            w_sat = w_sum[C-1:0];
        end else if (w_sum[SW-1]) begin
            w_sat = {1'b1, {(C-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(C-1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: if (i_start) n_state = DV_MUL;
            DV_MUL:  n_state = (r_uk == '0) ? DV_IDLE : DV_DIV;
            DV_DIV:  if (r_cnt == CW'(PW - 1)) n_state = DV_SAT;
            DV_SAT:  n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        n_ud     = r_ud;
        n_ue     = r_ue;
        n_uk     = r_uk;
        n_neg    = r_neg;
        n_a1     = r_a1;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_result = r_result;
        n_done   = 1'b0;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_ud  = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);
                    n_ue  = w_e[DW-1] ? DW'(-w_e) : DW'(w_e);
                    n_uk  = w_k[DW-1] ? DW'(-w_k) : DW'(w_k);
                    n_neg = w_d[DW-1] ^ w_e[DW-1] ^ w_k[DW-1];
                    n_a1  = i_a1;
                end
            end
            DV_MUL: begin
                n_prod = w_mul[PW-1:0];
                n_rem  = '0;
                n_cnt  = '0;
                if (r_uk == '0) begin
                    n_result = r_a1;
                    n_done   = 1'b1;
                end
            end
            DV_DIV: begin
                n_rem  = w_ge ? w_trial[DW-1:0] : w_rem_sh[DW-1:0];
                n_prod = {r_prod[PW-2:0], w_ge};
                n_cnt  = r_cnt + 1'b1;
            end
            DV_SAT: begin
                n_result = w_sat;
                n_done   = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_ud     <= n_ud;
        r_ue     <= n_ue;
        r_uk     <= n_uk;
        r_neg    <= n_neg;
        r_a1     <= n_a1;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

// File: rtl/line_segment_window_clip_core.sv
// Channel   | Direction | Handshake                       | Content
// s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | segment endpoints
// m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | accept flag, clipped endpoints
// cfg       | in        | i_cfg_valid/o_cfg_ready         | window register write
//
// One segment at a time: the next request is taken only once the last segment has run
// its P = 0..4 clip passes, each an interpolation by the interpolation unit, whose
// divider is bit-serial.
// A result waits in the output register; the next segment is taken meanwhile,
// and a finished segment holds until that register frees.
// Synchronous active-low reset opens the window to the full coordinate range.
`default_nettype none
module line_segment_window_clip_core import lsclip_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // start_row, start_col, end_row, end_col
    input  wire  [((4*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // clip_start_row, clip_start_col, clip_end_row, clip_end_col
    output logic [((4*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // accepted
    output logic                              o_m_axis_tuser,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [1:0]                        i_cfg_index,
    input  wire  [COORD_BITS-1:0]             i_cfg_data
);

    localparam int C  = COORD_BITS;
    localparam int TW = ((4 * C + 7) / 8) * 8;
    localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};

    t_state r_state, n_state;

    logic signed [C-1:0] r_row_min, r_row_max, r_col_min, r_col_max;
    logic signed [C-1:0] r_r0, n_r0, r_c0, n_c0, r_r1, n_r1, r_c1, n_c1;
    logic signed [C-1:0] r_edge, n_edge;
    logic [2:0]          r_pass, n_pass;
    logic                r_acc, n_acc, r_first, n_first, r_row_edge, n_row_edge;
    logic                r_out_valid, n_out_valid, r_out_user, n_out_user;
    logic [TW-1:0]       r_out_data, n_out_data;

    t_outcode            w_k0, w_k1, w_k;
    logic                w_in_acc, w_out_free, w_all_in, w_reject, w_start, w_done;
    logic signed [C-1:0] w_a1, w_a2, w_b1, w_b2, w_edge, w_result, w_nr, w_nc;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_min <= CMIN;
            r_row_max <= CMAX;
            r_col_min <= CMIN;
            r_col_max <= CMAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW_MIN: r_row_min <= i_cfg_data;
                REG_ROW_MAX: r_row_max <= i_cfg_data;
                REG_COL_MIN: r_col_min <= i_cfg_data;
                REG_COL_MAX: r_col_max <= i_cfg_data;
                default:     r_row_min <= r_row_min;
            endcase
        end
    end

    always_comb begin
        w_k0 = '0;
        if (r_r0 > r_row_max)      w_k0 = w_k0 | OC_ROW_HI;
        else if (r_r0 < r_row_min) w_k0 = w_k0 | OC_ROW_LO;
        if (r_c0 > r_col_max)      w_k0 = w_k0 | OC_COL_HI;
        else if (r_c0 < r_col_min) w_k0 = w_k0 | OC_COL_LO;
        w_k1 = '0;
        if (r_r1 > r_row_max)      w_k1 = w_k1 | OC_ROW_HI;
        else if (r_r1 < r_row_min) w_k1 = w_k1 | OC_ROW_LO;
        if (r_c1 > r_col_max)      w_k1 = w_k1 | OC_COL_HI;
        else if (r_c1 < r_col_min) w_k1 = w_k1 | OC_COL_LO;
    end

    assign w_k      = (w_k0 != '0) ? w_k0 : w_k1;
    assign w_all_in = (w_k0 | w_k1) == '0;
    assign w_reject = ((w_k0 & w_k1) != '0) || (r_pass >= MAX_PASSES);

    always_comb begin
        if ((w_k & OC_ROW_LO) != '0) begin
            w_a1 = r_c0; w_a2 = r_c1; w_b1 = r_r0; w_b2 = r_r1; w_edge = r_row_min;
        end else if ((w_k & OC_ROW_HI) != '0) begin
            w_a1 = r_c0; w_a2 = r_c1; w_b1 = r_r0; w_b2 = r_r1; w_edge = r_row_max;
        end else if ((w_k & OC_COL_HI) != '0) begin
            w_a1 = r_r0; w_a2 = r_r1; w_b1 = r_c0; w_b2 = r_c1; w_edge = r_col_max;
        end else begin
            w_a1 = r_r0; w_a2 = r_r1; w_b1 = r_c0; w_b2 = r_c1; w_edge = r_col_min;
        end
    end

    assign w_start = (r_state == ST_EVAL) && !w_all_in && !w_reject;

    lsclip_interp #(
        .COORD_BITS(COORD_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a1    (w_a1),
        .i_a2    (w_a2),
        .i_b1    (w_b1),
        .i_b2    (w_b2),
        .i_edge  (w_edge),
        .o_done  (w_done),
        .o_result(w_result)
    );

    assign w_nr = r_row_edge ? r_edge : w_result;
    assign w_nc = r_row_edge ? w_result : r_edge;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_EVAL;
            ST_EVAL: n_state = (w_all_in || w_reject) ? ST_DONE : ST_WAIT;
            ST_WAIT: if (w_done) n_state = ST_EVAL;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_r0        = r_r0;
        n_c0        = r_c0;
        n_r1        = r_r1;
        n_c1        = r_c1;
        n_pass      = r_pass;
        n_acc       = r_acc;
        n_first     = r_first;
        n_row_edge  = r_row_edge;
        n_edge      = r_edge;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_r0   = i_s_axis_tdata[0*C +: C];
                    n_c0   = i_s_axis_tdata[1*C +: C];
                    n_r1   = i_s_axis_tdata[2*C +: C];
                    n_c1   = i_s_axis_tdata[3*C +: C];
                    n_pass = '0;
                end
            end
            ST_EVAL: begin
                n_acc      = w_all_in;
                n_first    = w_k0 != '0;
                n_row_edge = (w_k & (OC_ROW_LO | OC_ROW_HI)) != '0;
                n_edge     = w_edge;
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_pass = r_pass + 1'b1;
                    if (r_first) begin
                        n_r0 = w_nr;
                        n_c0 = w_nc;
                    end else begin
                        n_r1 = w_nr;
                        n_c1 = w_nc;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_acc;
                    n_out_data  = '0;
                    if (r_acc) begin
                        n_out_data[0*C +: C] = r_r0;
                        n_out_data[1*C +: C] = r_c0;
                        n_out_data[2*C +: C] = r_r1;
                        n_out_data[3*C +: C] = r_c1;
                    end
                end
            end
            default: begin
                n_pass = r_pass;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_r0       <= n_r0;
        r_c0       <= n_c0;
        r_r1       <= n_r1;
        r_c1       <= n_c1;
        r_pass     <= n_pass;
        r_acc      <= n_acc;
        r_first    <= n_first;
        r_row_edge <= n_row_edge;
        r_edge     <= n_edge;
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_cfg_ready     = 1'b1;

endmodule
`default_nettype wire

// File: rtl/lsclip_checker.sv
`default_nettype none
`include "line_segment_window_clip_core_defines.svh"
module lsclip_checker #(
    parameter int COORD_BITS = 24
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_s_axis_tvalid,
    input wire                               o_s_axis_tready,
    input wire                               o_m_axis_tvalid,
    input wire                               i_m_axis_tready,
    input wire  [((4*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input wire                               o_m_axis_tuser
);

    localparam int TW = ((4 * COORD_BITS + 7) / 8) * 8;

    logic          w_in_take, w_in_idle, w_out_wait, w_out_reject;
    logic [TW:0]   w_out_bus;

    assign w_in_take    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_idle    = !o_m_axis_tvalid && o_s_axis_tready;
    assign w_out_wait   = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_reject = o_m_axis_tvalid && !o_m_axis_tuser;
    assign w_out_bus    = {o_m_axis_tuser, o_m_axis_tdata};

    `LSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_m_axis_tvalid && $stable(w_out_bus))
    `LSC_ASSERT_SAME(a_reject_zero, i_clk, i_rst_n, w_out_reject, o_m_axis_tdata == '0)
    `LSC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_in_take, !o_s_axis_tready)
    `LSC_ASSERT_NEXT(a_result_from_busy, i_clk, i_rst_n, w_in_idle, !o_m_axis_tvalid)

endmodule

bind line_segment_window_clip_core lsclip_checker #(
    .COORD_BITS(COORD_BITS)
) u_lsclip_checker (.*);
`default_nettype wire

// File: verif/tb_line_segment_window_clip_core.sv
`default_nettype none
module tb_line_segment_window_clip_core;
    import lsclip_pkg::*;

    localparam int     CW   = 24;
    localparam int     DW   = ((4*CW+7)/8)*8;
    localparam longint CMAX = (longint'(1) << (CW-1)) - 1;
    localparam longint CMIN = -(longint'(1) << (CW-1));
    localparam longint QCAP = longint'(1) << 36;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t end_col;
        coord_t end_row;
        coord_t start_col;
        coord_t start_row;
    } segment_t;

    typedef struct {
        logic     accepted;
        segment_t pts;
    } clip_t;

    typedef enum {
        WIN_TYPICAL,
        WIN_EXTREME,
        WIN_FLAT,
        WIN_INVERTED,
        WIN_TINY,
        WIN_WILD,
        WIN_FLIPPED_EDGE
    } win_kind_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    function automatic longint sat_coord(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    class segment_clip_model;
        longint win [4];
        clip_t  clipped_q [$];
        int     mismatches;

        function new();
            win[REG_ROW_MIN] = CMIN;
            win[REG_ROW_MAX] = CMAX;
            win[REG_COL_MIN] = CMIN;
            win[REG_COL_MAX] = CMAX;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, coord_t v);
            win[idx] = v;
        endfunction

        function t_outcode region(longint r, longint c);
            t_outcode k = '0;
            if (r > win[REG_ROW_MAX]) k |= OC_ROW_HI;
            else if (r < win[REG_ROW_MIN]) k |= OC_ROW_LO;
            if (c > win[REG_COL_MAX]) k |= OC_COL_HI;
            else if (c < win[REG_COL_MIN]) k |= OC_COL_LO;
            return k;
        endfunction

        function longint lerp(longint a1, longint a2, longint b1, longint b2, longint edge_v);
            longint d, e, k, q;
            bit     neg;
            d = a2 - a1;
            e = edge_v - b1;
            k = b2 - b1;
            if (k == 0) return a1;
            neg = ((d < 0) != (e < 0)) != (k < 0);
            if (d < 0) d = -d;
            if (e < 0) e = -e;
            if (k < 0) k = -k;
            q = (d * e) / k;
            if (q > QCAP) q = QCAP;
            return sat_coord(neg ? a1 - q : a1 + q);
        endfunction

        function clip_t clip_segment(segment_t s);
            longint   r0, c0, r1, c1, nr, nc;
            t_outcode k0, k1, k;
            clip_t    res;
            int       pass;
            r0 = s.start_row;
            c0 = s.start_col;
            r1 = s.end_row;
            c1 = s.end_col;
            k0 = region(r0, c0);
            k1 = region(r1, c1);
            res.accepted = 1'b0;
            res.pts = '0;
            for (pass = 0; pass <= MAX_PASSES; pass++) begin
                if ((k0 | k1) == 0) begin
                    res.accepted = 1'b1;
                    break;
                end
                if ((k0 & k1) != 0 || pass == MAX_PASSES) break;
                k = (k0 != 0) ? k0 : k1;
                if (k & OC_ROW_LO) begin
                    nr = win[REG_ROW_MIN];
                    nc = lerp(c0, c1, r0, r1, nr);
                end else if (k & OC_ROW_HI) begin
                    nr = win[REG_ROW_MAX];
                    nc = lerp(c0, c1, r0, r1, nr);
                end else if (k & OC_COL_HI) begin
                    nc = win[REG_COL_MAX];
                    nr = lerp(r0, r1, c0, c1, nc);
                end else begin
                    nc = win[REG_COL_MIN];
                    nr = lerp(r0, r1, c0, c1, nc);
                end
                if (k == k0) begin
                    r0 = nr;
                    c0 = nc;
                    k0 = region(r0, c0);
                end else begin
                    r1 = nr;
                    c1 = nc;
                    k1 = region(r1, c1);
                end
            end
            if (res.accepted) begin
                res.pts.start_row = r0[CW-1:0];
                res.pts.start_col = c0[CW-1:0];
                res.pts.end_row   = r1[CW-1:0];
                res.pts.end_col   = c1[CW-1:0];
            end
            return res;
        endfunction

        function void note_segment(segment_t s);
            clipped_q.push_back(clip_segment(s));
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_clipped(logic acc, segment_t pts);
            clip_t want;
            if (clipped_q.size() == 0) begin
                $error("result with no segment pending: accepted %0d", acc);
                mismatches++;
                return;
            end
            want = clipped_q.pop_front();
            compare_field("accepted", {63'd0, want.accepted}, {63'd0, acc});
            compare_field("clip_start_row", want.pts.start_row, pts.start_row);
            compare_field("clip_start_col", want.pts.start_col, pts.start_col);
            compare_field("clip_end_row", want.pts.end_row, pts.end_row);
            compare_field("clip_end_col", want.pts.end_col, pts.end_col);
        endfunction

        function int pending();
            return clipped_q.size();
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            s_valid;
    logic            s_ready;
    segment_t        s_data;
    logic            m_valid;
    logic            m_ready;
    logic [DW-1:0]   m_data;
    logic            m_user;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [1:0]      cfg_index;
    coord_t          cfg_data;

    segment_clip_model model = new();
    int              burst_left = 1;

    line_segment_window_clip_core #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic segment_t seg4(longint r0, longint c0, longint r1, longint c1);
        segment_t s;
        s.start_row = coord_t'(r0);
        s.start_col = coord_t'(c0);
        s.end_row   = coord_t'(r1);
        s.end_col   = coord_t'(c1);
        return s;
    endfunction

    function automatic coord_t pick_coord(longint a, longint b);
        longint lo, hi, margin;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ($urandom_range(11))
            0, 1: return coord_t'($urandom());
            2: return coord_t'(lo);
            3: return coord_t'(hi);
            4: return coord_t'(sat_coord(lo - 1));
            5: return coord_t'(sat_coord(hi + 1));
            6: return ($urandom_range(1) != 0) ? coord_t'(CMIN) : coord_t'(CMAX);
            default: begin
                margin = (hi - lo) / 2 + 64;
                lo = sat_coord(lo - margin);
                hi = sat_coord(hi + margin);
                return coord_t'(lo + $urandom_range(int'(hi - lo)));
            end
        endcase
    endfunction

    task automatic push_segment(segment_t seg, bit closes_phase);
        int gap;
        s_valid <= 1'b1;
        s_data  <= seg;
        do @(posedge clk); while (!s_ready);
        model.note_segment(seg);
        burst_left--;
        if (burst_left <= 0 || closes_phase) s_valid <= 1'b0;
        if (burst_left <= 0) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 1);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(300, 50)
                                                  : $urandom_range(24, 1);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic window_write(logic [1:0] idx, longint v, bit closes);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= coord_t'(v);
        do @(posedge clk); while (!cfg_ready);
        model.write_reg(idx, coord_t'(v));
        if (closes) cfg_valid <= 1'b0;
    endtask

    task automatic set_window(longint rlo, longint rhi, longint clo, longint chi);
        while (model.pending() != 0) @(posedge clk);
        window_write(REG_ROW_MIN, rlo, 1'b0);
        window_write(REG_ROW_MAX, rhi, 1'b0);
        window_write(REG_COL_MIN, clo, 1'b0);
        window_write(REG_COL_MAX, chi, 1'b1);
    endtask

    task automatic random_window(win_kind_t kind);
        longint rc, cc, rh, ch, rlo, rhi, clo, chi;
        rc = $urandom_range(8388608);
        rc = rc - 4194304;
        cc = $urandom_range(8388608);
        cc = cc - 4194304;
        rh = $urandom_range(1 << 20, 256);
        ch = $urandom_range(1 << 20, 256);
        rlo = sat_coord(rc - rh);
        rhi = sat_coord(rc + rh);
        clo = sat_coord(cc - ch);
        chi = sat_coord(cc + ch);
        case (kind)
            WIN_EXTREME: begin
                rlo = CMIN;
                rhi = CMAX;
                chi = CMAX;
            end
            WIN_FLAT: rhi = rlo;
            WIN_INVERTED: begin
                {rlo, rhi} = {rhi, rlo};
                {clo, chi} = {chi, clo};
            end
            WIN_TINY: begin
                rlo = sat_coord(rc - $urandom_range(255));
                rhi = sat_coord(rc + $urandom_range(255));
                clo = sat_coord(cc - $urandom_range(255));
                chi = sat_coord(cc + $urandom_range(255));
            end
            WIN_WILD: begin
                rlo = coord_t'($urandom());
                rhi = coord_t'($urandom());
                clo = coord_t'($urandom());
                chi = coord_t'($urandom());
            end
            WIN_FLIPPED_EDGE: begin
                rlo = CMAX;
                rhi = CMIN;
                clo = CMIN;
            end
            default: ;
        endcase
        set_window(rlo, rhi, clo, chi);
    endtask

    initial begin
        rx_mode_t    mode;
        int          left;
        int unsigned cyc;
        mode = RX_OPEN;
        left = 0;
        cyc  = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_valid && m_ready) model.check_clipped(m_user, m_data);
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(3));
                left = $urandom_range(600, 50);
            end
            left--;
            cyc++;
            case (mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= ($urandom_range(1) != 0);
                RX_SPARSE: m_ready <= (cyc % 8 == 0);
                default:   m_ready <= ($urandom_range(9) != 0);
            endcase
        end
    end

    initial begin
        #50_000_000;
        $display("** line_segment_window_clip_core: FAILED **");
        $finish;
    end

    initial begin
        win_kind_t plan [8];
        segment_t  seg;
        int        p, i;
        plan = '{WIN_TYPICAL, WIN_EXTREME, WIN_FLAT, WIN_INVERTED,
                 WIN_TINY, WIN_WILD, WIN_TYPICAL, WIN_FLIPPED_EDGE};
        rst_n     <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ROW_MIN;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_segment(seg4(CMIN, CMIN, CMIN, CMIN), 1'b0);
        push_segment(seg4(CMAX, CMAX, CMAX, CMAX), 1'b0);
        push_segment(seg4(CMIN, CMAX, CMAX, CMIN), 1'b0);
        push_segment(seg4(0, 0, 0, 0), 1'b1);

        set_window(-25600, 25600, -12800, 38400);
        push_segment(seg4(0, 0, 1000, 2000), 1'b0);
        push_segment(seg4(-30000, 0, -40000, 100), 1'b0);
        push_segment(seg4(30000, 0, 40000, -100), 1'b0);
        push_segment(seg4(0, 40000, 100, 50000), 1'b0);
        push_segment(seg4(0, -20000, 100, -30000), 1'b0);
        push_segment(seg4(-51200, -12800, 0, 25600), 1'b0);
        push_segment(seg4(0, 0, 51200, 30000), 1'b0);
        push_segment(seg4(100, 0, -300, 60000), 1'b0);
        push_segment(seg4(100, 0, 900, -60000), 1'b0);
        push_segment(seg4(-51200, -51200, 51200, 51200), 1'b0);
        push_segment(seg4(-51200, 30000, -20000, 60000), 1'b0);
        push_segment(seg4(-25600, -12800, 25600, 38400), 1'b0);
        push_segment(seg4(CMIN, CMIN, CMAX, CMAX), 1'b0);
        push_segment(seg4(CMAX, CMIN, CMIN, CMAX), 1'b1);

        set_window(1000, -1000, CMIN, CMAX);
        push_segment(seg4(-1001, 0, -999, 8000000), 1'b0);
        push_segment(seg4(-1001, CMIN, -999, CMAX), 1'b0);
        push_segment(seg4(0, 0, 5, 5), 1'b1);

        for (p = 0; p < 8; p++) begin
            random_window(plan[p]);
            for (i = 0; i < 190; i++) begin
                seg.start_row = pick_coord(model.win[REG_ROW_MIN], model.win[REG_ROW_MAX]);
                seg.start_col = pick_coord(model.win[REG_COL_MIN], model.win[REG_COL_MAX]);
                seg.end_row   = pick_coord(model.win[REG_ROW_MIN], model.win[REG_ROW_MAX]);
                seg.end_col   = pick_coord(model.win[REG_COL_MIN], model.win[REG_COL_MAX]);
                push_segment(seg, i == 189);
            end
        end

        while (model.pending() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        if (model.mismatches == 0) begin
            $display("** line_segment_window_clip_core: PASSED **");
        end else begin
            $display("** line_segment_window_clip_core: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
